### hw/rtl/iobic_pkg.sv
package iobic_pkg;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_DEV_INT = 2'd2,
        OP_EXT_INT = 2'd3
    } t_op;

    // Register groups.
    localparam logic [3:0] GRP_MAP       = 4'd0;
    localparam logic [3:0] GRP_CTL       = 4'd1;
    localparam logic [3:0] GRP_EXT_VEC   = 4'd2;
    localparam logic [3:0] GRP_DISPATCH  = 4'd3;
    localparam logic [3:0] GRP_DATA0     = 4'd4;
    localparam logic [3:0] GRP_DATA1     = 4'd5;
    localparam logic [3:0] GRP_OWN_DATA0 = 4'd6;
    localparam logic [3:0] GRP_OWN_DATA1 = 4'd7;
    localparam logic [3:0] GRP_BUSY      = 4'd8;
    localparam logic [3:0] GRP_OWN_BUSY  = 4'd9;

    // Dispatch types; the non-interrupt types double as CPU command codes.
    localparam logic [1:0] DISP_INTERRUPT = 2'd0;
    localparam logic [1:0] DISP_RESET     = 2'd1;
    localparam logic [1:0] CMD_NONE       = 2'd0;

    // Bit positions inside register write data.
    localparam int DISP_TYPE_LSB = 16;
    localparam int MAP_CPU_LSB   = 8;
    localparam int CTL_MASK_BIT  = 2;
    localparam int CTL_CLR_BIT   = 1;
    localparam int BUSY_BIT      = 5;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  reg_group;
        logic [4:0]  index;
        logic [4:0]  requester_cpu;
        logic [63:0] write_data;
        logic [4:0]  source_id;
        logic [63:0] data_word0;
        logic [63:0] data_word1;
    } t_in_word;

    typedef struct packed {
        logic [63:0] read_data;
        logic        access_error;
        logic        post_valid;
        logic [4:0]  post_cpu;
        logic [5:0]  post_vector;
        logic [1:0]  cpu_command;
        logic [4:0]  command_cpu;
        logic        ext_accepted;
    } t_out_word;

    // One device entry.
    typedef struct packed {
        logic [4:0] target_cpu;
        logic [5:0] vector;
        logic       mask;
        logic       pending;
    } t_dev_entry;

    // One per-CPU external interrupt entry.
    typedef struct packed {
        logic        busy;
        logic [4:0]  source;
        logic [63:0] data0;
        logic [63:0] data1;
    } t_cpu_entry;

    localparam t_dev_entry DEV_RESET = '{target_cpu: 5'd0, vector: 6'd0,
                                         mask: 1'b1, pending: 1'b0};

endpackage

### hw/rtl/io_bridge_interrupt_controller_top.sv
// Channel   Direction  Handshake                 Word
// in        input      i_in_valid / o_in_stall   iobic_pkg::t_in_word
// out       output     o_out_valid / i_out_stall iobic_pkg::t_out_word
// cfg       input      i_cfg_we                  num_cpus_present, 6 bits
//
// The device and CPU memories are read in the accept cycle, and the entry is
// modified and written back in the execute state once the output can take it.
// A new word is taken once the previous one has left for the output register.
// Reset is synchronous and stalls the input while held; valid bits make every
// memory entry read as its reset value until written, so no clearing pass is needed.
// A stalled output holds the finished word and keeps the block from finishing
// the next one.
module io_bridge_interrupt_controller_top #(
    parameter int DEVICE_COUNT    = 4,
    parameter int CPU_COUNT       = 32,
    parameter int RESET_TRAP_TYPE = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  iobic_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output iobic_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_wdata
);

    localparam int DAW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam int CAW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int DEW = $bits(iobic_pkg::t_dev_entry);
    localparam int CEW = $bits(iobic_pkg::t_cpu_entry);

    // CPU that an item addresses: the requester for the own-CPU groups.
    function automatic logic [4:0] cpu_of(iobic_pkg::t_in_word w);
        logic own;
        own = (w.op == iobic_pkg::OP_READ || w.op == iobic_pkg::OP_WRITE) &&
              (w.reg_group == iobic_pkg::GRP_OWN_DATA0 ||
               w.reg_group == iobic_pkg::GRP_OWN_DATA1 ||
               w.reg_group == iobic_pkg::GRP_OWN_BUSY);
        return own ? w.requester_cpu : w.index;
    endfunction

    iobic_pkg::t_state     r_state, n_state;
    iobic_pkg::t_in_word   r_item;
    iobic_pkg::t_in_word   sel_item;
    iobic_pkg::t_out_word  r_out, res;
    logic                  r_out_valid;
    logic [5:0]            r_num_cpus;
    logic [5:0]            r_ext_vector, n_ext_vector;
    logic [DEVICE_COUNT-1:0] r_dev_valid;
    logic [CPU_COUNT-1:0]  r_cpu_valid;
    logic                  fire;

    logic [DAW-1:0]        dev_raddr, dev_addr;
    logic [CAW-1:0]        cpu_raddr, cpu_addr;
    logic [DEW-1:0]        dev_rdata;
    logic [CEW-1:0]        cpu_rdata;
    iobic_pkg::t_dev_entry dev_cur, dev_new;
    iobic_pkg::t_cpu_entry cpu_cur, cpu_new;
    logic                  dev_wr, cpu_wr, dev_we, cpu_we;
    logic                  dev_in_range, cpu_in_range, wr;
    logic [4:0]            cpu_sel;
    logic [4:0]            sel_cpu;
    logic [63:0]           wd;
    logic [1:0]            disp_type;
    logic [4:0]            disp_cpu;
    logic [5:0]            disp_vec;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iobic_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = iobic_pkg::S_EXEC;
                end
            end
            iobic_pkg::S_EXEC: begin
                if (fire) begin
                    n_state = iobic_pkg::S_IDLE;
                end
            end
            default: n_state = iobic_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        fire       = 1'b0;
        sel_item   = r_item;
        unique case (r_state)
            iobic_pkg::S_IDLE: begin
                o_in_stall = !i_rst_n;
                sel_item   = i_in_word;
            end
            iobic_pkg::S_EXEC: begin
                fire = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // The read address follows the incoming word while idle so that the entry
    // is ready in the execute cycle; it is reissued from the held word on a stall.
    assign sel_cpu   = cpu_of(sel_item);
    assign dev_raddr = sel_item.index[DAW-1:0];
    assign cpu_raddr = sel_cpu[CAW-1:0];

    iobic_ram #(.WIDTH(DEW), .DEPTH(DEVICE_COUNT)) u_dev_ram (
        .i_clk   (i_clk),
        .i_we    (dev_we),
        .i_waddr (dev_addr),
        .i_wdata (dev_new),
        .i_raddr (dev_raddr),
        .o_rdata (dev_rdata)
    );

    iobic_ram #(.WIDTH(CEW), .DEPTH(CPU_COUNT)) u_cpu_ram (
        .i_clk   (i_clk),
        .i_we    (cpu_we),
        .i_waddr (cpu_addr),
        .i_wdata (cpu_new),
        .i_raddr (cpu_raddr),
        .o_rdata (cpu_rdata)
    );

    assign cpu_sel      = cpu_of(r_item);
    assign dev_addr     = r_item.index[DAW-1:0];
    assign cpu_addr     = cpu_sel[CAW-1:0];
    assign dev_in_range = {1'b0, r_item.index} < 6'(DEVICE_COUNT);
    assign cpu_in_range = {1'b0, cpu_sel} < 6'(CPU_COUNT);
    assign dev_cur      = (dev_in_range && r_dev_valid[dev_addr]) ?
                          iobic_pkg::t_dev_entry'(dev_rdata) : iobic_pkg::DEV_RESET;
    assign cpu_cur      = (cpu_in_range && r_cpu_valid[cpu_addr]) ?
                          iobic_pkg::t_cpu_entry'(cpu_rdata) : '0;
    assign wr           = (r_item.op == iobic_pkg::OP_WRITE);
    assign wd           = r_item.write_data;
    assign disp_type    = wd[iobic_pkg::DISP_TYPE_LSB +: 2];
    assign disp_cpu     = wd[iobic_pkg::MAP_CPU_LSB +: 5];
    assign disp_vec     = wd[5:0];
    assign dev_we       = fire && dev_wr;
    assign cpu_we       = fire && cpu_wr;

    // Execute: decode the held word against the entries just read.
    always_comb begin
        res          = '0;
        dev_new      = dev_cur;
        cpu_new      = cpu_cur;
        dev_wr       = 1'b0;
        cpu_wr       = 1'b0;
        n_ext_vector = r_ext_vector;
        unique case (r_item.op) inside
            iobic_pkg::OP_READ, iobic_pkg::OP_WRITE: begin
                if (r_item.reg_group > iobic_pkg::GRP_OWN_BUSY) begin
                    res.access_error = 1'b1;
                end else if (r_item.reg_group == iobic_pkg::GRP_MAP ||
                             r_item.reg_group == iobic_pkg::GRP_CTL) begin
                    if (!dev_in_range) begin
                        res.access_error = 1'b1;
                    end else if (r_item.reg_group == iobic_pkg::GRP_MAP) begin
                        if (wr) begin
                            dev_new.target_cpu = wd[iobic_pkg::MAP_CPU_LSB +: 5];
                            dev_new.vector     = wd[5:0];
                            dev_wr             = 1'b1;
                        end else begin
                            res.read_data = 64'({dev_cur.target_cpu, 2'b00,
                                                 dev_cur.vector});
                        end
                    end else begin
                        if (wr) begin
                            dev_new.mask = wd[iobic_pkg::CTL_MASK_BIT];
                            if (wd[iobic_pkg::CTL_CLR_BIT]) begin
                                dev_new.pending = 1'b0;
                            end
                            dev_wr = 1'b1;
                        end else begin
                            res.read_data = 64'({dev_cur.mask, 1'b0, dev_cur.pending});
                        end
                    end
                end else if (r_item.reg_group == iobic_pkg::GRP_EXT_VEC) begin
                    if (wr) begin
                        n_ext_vector = wd[5:0];
                    end else begin
                        res.read_data = 64'(r_ext_vector);
                    end
                end else if (r_item.reg_group == iobic_pkg::GRP_DISPATCH) begin
                    if (!wr) begin
                        res.access_error = 1'b1;
                    end else if ({1'b0, disp_cpu} < r_num_cpus &&
                                 {1'b0, disp_cpu} < 6'(CPU_COUNT)) begin
                        if (disp_type == iobic_pkg::DISP_INTERRUPT) begin
                            res.post_valid  = 1'b1;
                            res.post_cpu    = disp_cpu;
                            res.post_vector = disp_vec;
                        end else if (disp_type == iobic_pkg::DISP_RESET &&
                                     disp_vec != 6'(RESET_TRAP_TYPE)) begin
                            // Only a power-on reset may be dispatched.
                            res.access_error = 1'b1;
                        end else begin
                            res.cpu_command = disp_type;
                            res.command_cpu = disp_cpu;
                        end
                    end
                end else if (!cpu_in_range) begin
                    res.access_error = 1'b1;
                end else if (r_item.reg_group == iobic_pkg::GRP_BUSY ||
                             r_item.reg_group == iobic_pkg::GRP_OWN_BUSY) begin
                    if (wr) begin
                        cpu_new.busy = wd[iobic_pkg::BUSY_BIT];
                        cpu_wr       = 1'b1;
                    end else begin
                        res.read_data = 64'({cpu_cur.busy, cpu_cur.source});
                    end
                end else if (wr) begin
                    res.access_error = 1'b1;
                end else if (r_item.reg_group == iobic_pkg::GRP_DATA0 ||
                             r_item.reg_group == iobic_pkg::GRP_OWN_DATA0) begin
                    res.read_data = cpu_cur.data0;
                end else begin
                    res.read_data = cpu_cur.data1;
                end
            end
            iobic_pkg::OP_DEV_INT: begin
                if (dev_in_range && !dev_cur.mask) begin
                    dev_new.mask    = 1'b1;
                    dev_new.pending = 1'b1;
                    dev_wr          = 1'b1;
                    res.post_valid  = 1'b1;
                    res.post_cpu    = dev_cur.target_cpu;
                    res.post_vector = dev_cur.vector;
                end
            end
            iobic_pkg::OP_EXT_INT: begin
                if (cpu_in_range && !cpu_cur.busy) begin
                    cpu_new.busy     = 1'b1;
                    cpu_new.source   = r_item.source_id;
                    cpu_new.data0    = r_item.data_word0;
                    cpu_new.data1    = r_item.data_word1;
                    cpu_wr           = 1'b1;
                    res.ext_accepted = 1'b1;
                    res.post_valid   = 1'b1;
                    res.post_cpu     = r_item.index;
                    res.post_vector  = r_ext_vector;
                end
            end
            default: begin
                res.access_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= iobic_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_num_cpus   <= 6'd32;
            r_ext_vector <= 6'd0;
            r_dev_valid  <= '0;
            r_cpu_valid  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num_cpus <= i_cfg_wdata;
            end
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_ext_vector <= n_ext_vector;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (dev_we) begin
                r_dev_valid[dev_addr] <= 1'b1;
            end
            if (cpu_we) begin
                r_cpu_valid[cpu_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_word;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == iobic_pkg::S_EXEC))
        else $error("accepted word did not enter execute");

    a_fire_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out_valid && r_state == iobic_pkg::S_IDLE))
        else $error("finished word not presented at the output");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dev_we || cpu_we) |-> (r_state == iobic_pkg::S_EXEC))
        else $error("memory written outside execute");

    a_post_or_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.post_valid && r_out.cpu_command != iobic_pkg::CMD_NONE))
        else $error("post and CPU command in the same word");

    a_ext_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ext_accepted) |-> r_out.post_valid)
        else $error("accepted external interrupt without a post");

endmodule

### hw/rtl/iobic_ram.sv
module iobic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### test/iobic_checker.sv
module iobic_checker #(
    parameter int DEVICE_COUNT    = 4,
    parameter int CPU_COUNT       = 32,
    parameter int RESET_TRAP_TYPE = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  iobic_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  iobic_pkg::t_out_word i_out_word,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_wdata,
    output int                   o_failures,
    output int                   o_words_due,
    output int                   o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [4:0]  dev_cpu  [DEVICE_COUNT];
    logic [5:0]  dev_vec  [DEVICE_COUNT];
    logic        dev_mask [DEVICE_COUNT];
    logic        dev_pend [DEVICE_COUNT];
    logic [5:0]  ext_vec;
    logic [63:0] cpu_data0 [CPU_COUNT];
    logic [63:0] cpu_data1 [CPU_COUNT];
    logic        cpu_busy  [CPU_COUNT];
    logic [4:0]  cpu_src   [CPU_COUNT];
    logic [5:0]  cpus_present;

    iobic_pkg::t_out_word due_words[$];
    int fails;
    int checked;

    function automatic void clear_state();
        for (int i = 0; i < DEVICE_COUNT; i++) begin
            dev_cpu[i]  = '0;
            dev_vec[i]  = '0;
            dev_mask[i] = 1'b1;
            dev_pend[i] = 1'b0;
        end
        for (int i = 0; i < CPU_COUNT; i++) begin
            cpu_data0[i] = '0;
            cpu_data1[i] = '0;
            cpu_busy[i]  = 1'b0;
            cpu_src[i]   = '0;
        end
        ext_vec      = '0;
        cpus_present = 6'd32;
    endfunction

    // Applies one word to the shadow state and returns the result it must produce.
    function automatic iobic_pkg::t_out_word service_word(iobic_pkg::t_in_word w);
        iobic_pkg::t_out_word r;
        logic        wr;
        logic [4:0]  cpu;
        logic [63:0] wd;
        logic [1:0]  kind;
        logic [4:0]  dcpu;
        logic [5:0]  dvec;
        r    = '0;
        wr   = (w.op == iobic_pkg::OP_WRITE);
        wd   = w.write_data;
        cpu  = (w.reg_group == iobic_pkg::GRP_OWN_DATA0 ||
                w.reg_group == iobic_pkg::GRP_OWN_DATA1 ||
                w.reg_group == iobic_pkg::GRP_OWN_BUSY) ? w.requester_cpu : w.index;
        if (w.op == iobic_pkg::OP_READ || w.op == iobic_pkg::OP_WRITE) begin
            if (w.reg_group > iobic_pkg::GRP_OWN_BUSY) begin
                r.access_error = 1'b1;
            end else if (w.reg_group == iobic_pkg::GRP_MAP ||
                         w.reg_group == iobic_pkg::GRP_CTL) begin
                if (w.index >= DEVICE_COUNT) begin
                    r.access_error = 1'b1;
                end else if (w.reg_group == iobic_pkg::GRP_MAP) begin
                    if (wr) begin
                        dev_cpu[w.index] = wd[iobic_pkg::MAP_CPU_LSB +: 5];
                        dev_vec[w.index] = wd[5:0];
                    end else begin
                        r.read_data = {51'd0, dev_cpu[w.index], 2'b00, dev_vec[w.index]};
                    end
                end else begin
                    if (wr) begin
                        dev_mask[w.index] = wd[iobic_pkg::CTL_MASK_BIT];
                        if (wd[iobic_pkg::CTL_CLR_BIT])
                            dev_pend[w.index] = 1'b0;
                    end else begin
                        r.read_data = {61'd0, dev_mask[w.index], 1'b0, dev_pend[w.index]};
                    end
                end
            end else if (w.reg_group == iobic_pkg::GRP_EXT_VEC) begin
                if (wr)
                    ext_vec = wd[5:0];
                else
                    r.read_data = {58'd0, ext_vec};
            end else if (w.reg_group == iobic_pkg::GRP_DISPATCH) begin
                if (!wr) begin
                    r.access_error = 1'b1;
                end else begin
                    kind = wd[iobic_pkg::DISP_TYPE_LSB +: 2];
                    dcpu = wd[iobic_pkg::MAP_CPU_LSB +: 5];
                    dvec = wd[5:0];
                    // CPUs that are not present swallow the dispatch silently.
                    if ({1'b0, dcpu} < cpus_present && dcpu < CPU_COUNT) begin
                        if (kind == iobic_pkg::DISP_INTERRUPT) begin
                            r.post_valid  = 1'b1;
                            r.post_cpu    = dcpu;
                            r.post_vector = dvec;
                        end else if (kind == iobic_pkg::DISP_RESET &&
                                     dvec != RESET_TRAP_TYPE) begin
                            r.access_error = 1'b1;
                        end else begin
                            r.cpu_command = kind;
                            r.command_cpu = dcpu;
                        end
                    end
                end
            end else if (cpu >= CPU_COUNT) begin
                r.access_error = 1'b1;
            end else if (w.reg_group == iobic_pkg::GRP_BUSY ||
                         w.reg_group == iobic_pkg::GRP_OWN_BUSY) begin
                if (wr)
                    cpu_busy[cpu] = wd[iobic_pkg::BUSY_BIT];
                else
                    r.read_data = {58'd0, cpu_busy[cpu], cpu_src[cpu]};
            end else if (wr) begin
                r.access_error = 1'b1;
            end else if (w.reg_group == iobic_pkg::GRP_DATA0 ||
                         w.reg_group == iobic_pkg::GRP_OWN_DATA0) begin
                r.read_data = cpu_data0[cpu];
            end else begin
                r.read_data = cpu_data1[cpu];
            end
        end else if (w.op == iobic_pkg::OP_DEV_INT) begin
            if (w.index < DEVICE_COUNT && !dev_mask[w.index]) begin
                dev_mask[w.index] = 1'b1;
                dev_pend[w.index] = 1'b1;
                r.post_valid  = 1'b1;
                r.post_cpu    = dev_cpu[w.index];
                r.post_vector = dev_vec[w.index];
            end
        end else begin
            if (w.index < CPU_COUNT && !cpu_busy[w.index]) begin
                cpu_busy[w.index]  = 1'b1;
                cpu_src[w.index]   = w.source_id;
                cpu_data0[w.index] = w.data_word0;
                cpu_data1[w.index] = w.data_word1;
                r.ext_accepted = 1'b1;
                r.post_valid   = 1'b1;
                r.post_cpu     = w.index;
                r.post_vector  = ext_vec;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    initial clear_state();

    always @(posedge i_clk) begin : watch
        iobic_pkg::t_out_word want;
        if (!i_rst_n) begin
            clear_state();
            due_words.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_we)
                cpus_present = i_cfg_wdata;
            // Retire before predicting so a result never matches the word taken
            // at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    $error("result word arrived with none expected");
                    fails++;
                end else begin
                    want = due_words.pop_front();
                    check_field("read_data",    want.read_data,    i_out_word.read_data);
                    check_field("access_error", want.access_error, i_out_word.access_error);
                    check_field("post_valid",   want.post_valid,   i_out_word.post_valid);
                    check_field("post_cpu",     want.post_cpu,     i_out_word.post_cpu);
                    check_field("post_vector",  want.post_vector,  i_out_word.post_vector);
                    check_field("cpu_command",  want.cpu_command,  i_out_word.cpu_command);
                    check_field("command_cpu",  want.command_cpu,  i_out_word.command_cpu);
                    check_field("ext_accepted", want.ext_accepted, i_out_word.ext_accepted);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall)
                due_words.insert(due_words.size(), service_word(i_in_word));
        end
        o_failures      <= fails;
        o_words_due     <= due_words.size();
        o_words_checked <= checked;
    end

endmodule

### test/io_bridge_interrupt_controller_top_test.sv
module io_bridge_interrupt_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEV_N      = 4;
    localparam int         CPU_N      = 32;
    localparam int         RESET_TRAP = 1;
    localparam logic [1:0] CMD_HALT   = 2'd2;
    localparam logic [1:0] CMD_RESUME = 2'd3;
    localparam int         PHASES     = 8;
    localparam int         PHASE_WORDS = 250;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    iobic_pkg::t_in_word  in_word   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [5:0]           cfg_wdata = 6'd0;
    logic                 in_stall;
    logic                 out_valid;
    iobic_pkg::t_out_word out_word;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int words_sent    = 0;
    int cfg_writes    = 0;
    int failures;
    int words_due;
    int words_checked;

    io_bridge_interrupt_controller_top #(
        .DEVICE_COUNT    (DEV_N),
        .CPU_COUNT       (CPU_N),
        .RESET_TRAP_TYPE (RESET_TRAP)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    iobic_checker #(
        .DEVICE_COUNT    (DEV_N),
        .CPU_COUNT       (CPU_N),
        .RESET_TRAP_TYPE (RESET_TRAP)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_word       (in_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_failures      (failures),
        .o_words_due     (words_due),
        .o_words_checked (words_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic iobic_pkg::t_in_word reg_word(iobic_pkg::t_op op, logic [3:0] grp,
                                                     logic [4:0] idx, logic [4:0] req,
                                                     logic [63:0] wd);
        iobic_pkg::t_in_word w;
        w.op            = op;
        w.reg_group     = grp;
        w.index         = idx;
        w.requester_cpu = req;
        w.write_data    = wd;
        w.source_id     = 5'($urandom);
        w.data_word0    = {$urandom, $urandom};
        w.data_word1    = {$urandom, $urandom};
        return w;
    endfunction

    function automatic logic [63:0] dispatch_data(logic [1:0] kind, logic [4:0] cpu,
                                                  logic [5:0] vec);
        return {46'd0, kind, 3'd0, cpu, 2'd0, vec};
    endfunction

    // Mostly well-formed accesses: device indexes in range, a small set of CPUs
    // so external interrupts collide with busy flags, and dispatch words with
    // meaningful fields; the rest is raw noise.
    function automatic iobic_pkg::t_in_word random_word();
        iobic_pkg::t_in_word w;
        int                  pick;
        w    = reg_word(iobic_pkg::OP_READ, iobic_pkg::GRP_MAP, 5'd0, 5'd0,
                        {$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 30)
            w.op = iobic_pkg::OP_READ;
        else if (pick < 65)
            w.op = iobic_pkg::OP_WRITE;
        else if (pick < 85)
            w.op = iobic_pkg::OP_DEV_INT;
        else
            w.op = iobic_pkg::OP_EXT_INT;
        if ($urandom_range(9) == 0)
            w.reg_group = 4'($urandom_range(15, 10));
        else
            w.reg_group = 4'($urandom_range(9));
        if (w.op == iobic_pkg::OP_DEV_INT || w.reg_group <= iobic_pkg::GRP_CTL)
            w.index = 5'(($urandom_range(3) != 0) ? $urandom_range(DEV_N - 1)
                                                  : $urandom_range(31));
        else
            w.index = 5'($urandom_range(1) ? $urandom_range(7) : $urandom_range(31));
        w.requester_cpu = 5'($urandom_range(1) ? $urandom_range(7) : $urandom_range(31));
        if (w.reg_group == iobic_pkg::GRP_DISPATCH && $urandom_range(1))
            w.write_data = dispatch_data(2'($urandom_range(3)), 5'($urandom_range(31)),
                                         6'($urandom_range(1) ? RESET_TRAP
                                                              : $urandom_range(63)));
        return w;
    endfunction

    task automatic send_word(input iobic_pkg::t_in_word w);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // Holds the sender off until every outstanding word has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cpus(input logic [5:0] count);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        iobic_pkg::t_in_word w;
        int                  cpu_plan [PHASES];
        int                  count;
        cpu_plan = '{32, 1, 0, 32, 1, 0, 0, 32};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, forbidden directions and unknown groups.
        send_word(reg_word(iobic_pkg::OP_READ,  iobic_pkg::GRP_MAP,      5'd0, 5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_READ,  iobic_pkg::GRP_CTL,      5'd0, 5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_READ,  iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_READ,  4'd15, 5'd31, 5'd31, '0));
        send_word(reg_word(iobic_pkg::OP_WRITE, 4'd10, 5'd0,  5'd0,  '1));

        // Device path: map, unmask, fire, pending, clear, masked and out of range.
        send_word(reg_word(iobic_pkg::OP_WRITE,   iobic_pkg::GRP_MAP, 5'd3,  5'd0, '1));
        send_word(reg_word(iobic_pkg::OP_WRITE,   iobic_pkg::GRP_CTL, 5'd3,  5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_DEV_INT, iobic_pkg::GRP_MAP, 5'd3,  5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_READ,    iobic_pkg::GRP_CTL, 5'd3,  5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_WRITE,   iobic_pkg::GRP_CTL, 5'd3,  5'd0, 64'h2));
        send_word(reg_word(iobic_pkg::OP_READ,    iobic_pkg::GRP_MAP, 5'd3,  5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_DEV_INT, iobic_pkg::GRP_MAP, 5'd0,  5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_DEV_INT, iobic_pkg::GRP_MAP, 5'd31, 5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_WRITE,   iobic_pkg::GRP_MAP, 5'd31, 5'd0, '1));
        send_word(reg_word(iobic_pkg::OP_READ,    iobic_pkg::GRP_CTL, 5'd4,  5'd0, '0));

        // External path: accept, refuse while busy, read back, release.
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_EXT_VEC, 5'd0, 5'd0, '1));
        w = reg_word(iobic_pkg::OP_EXT_INT, iobic_pkg::GRP_MAP, 5'd31, 5'd0, '0);
        w.source_id  = '1;
        w.data_word0 = '1;
        w.data_word1 = '1;
        send_word(w);
        send_word(reg_word(iobic_pkg::OP_EXT_INT, iobic_pkg::GRP_MAP,  5'd31, 5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_READ,    iobic_pkg::GRP_BUSY, 5'd31, 5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_READ, iobic_pkg::GRP_OWN_DATA0, 5'd0, 5'd31, '0));
        send_word(reg_word(iobic_pkg::OP_READ, iobic_pkg::GRP_DATA1, 5'd31, 5'd0, '0));
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_OWN_BUSY, 5'd0, 5'd31, '0));
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DATA0, 5'd31, 5'd0, '1));

        // Dispatch of each type, including a reset that is not a power-on reset.
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0,
                           dispatch_data(iobic_pkg::DISP_INTERRUPT, 5'd31, 6'd63)));
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0,
                           dispatch_data(iobic_pkg::DISP_RESET, 5'd0, 6'(RESET_TRAP))));
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0,
                           dispatch_data(iobic_pkg::DISP_RESET, 5'd7, 6'd0)));
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0,
                           dispatch_data(CMD_HALT, 5'd5, 6'd9)));
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0,
                           dispatch_data(CMD_RESUME, 5'd31, 6'd0)));

        // With a single CPU present, dispatch to any other CPU is dropped.
        write_cpus(6'd1);
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0,
                           dispatch_data(iobic_pkg::DISP_INTERRUPT, 5'd1, 6'd3)));
        send_word(reg_word(iobic_pkg::OP_WRITE, iobic_pkg::GRP_DISPATCH, 5'd0, 5'd0,
                           dispatch_data(CMD_HALT, 5'd0, 6'd0)));

        for (int p = 0; p < PHASES; p++) begin
            count = (cpu_plan[p] != 0) ? cpu_plan[p] : $urandom_range(31, 2);
            write_cpus(6'(count));
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 69;
                end
                default: begin
                    send_idle_pct = 27;
                    stall_pct     = 27;
                end
            endcase
            repeat (PHASE_WORDS) send_word(random_word());
        end

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Sent %0d words across %0d idle and stall phases; %0d results checked,",
                 words_sent, PHASES, words_checked);
        $display("with %0d writes of the present-CPU count between 1 and 32.", cfg_writes);
        if (failures == 0 && words_due == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/iobic_pkg.sv
hw/rtl/iobic_ram.sv
hw/rtl/io_bridge_interrupt_controller_top.sv
test/iobic_checker.sv
test/io_bridge_interrupt_controller_top_test.sv
